// ----- hw/rtl/tcf_pkg.sv -----
// tilt complementary filter: shared widths, defaults and the cordic arctangent table
// used by tcf_cordic and tilt_complementary_filter_unit, no dependencies
package tcf_pkg;

    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 16;

    localparam int SAMPLE_W   = 16;
    localparam int ANGLE_W    = 32;
    localparam int TABLE_LEN  = 24;
    localparam int TABLE_IDX_W = 5;
    localparam int TABLE_FRAC = 24;
    localparam int INPUT_SHIFT = 8;
    localparam int XY_W       = SAMPLE_W + INPUT_SHIFT + 3;
    localparam int Z_W        = 34;
    localparam int ATAN_W     = 30;

    localparam logic [15:0] GYRO_SCALE_RST = 16'd40;
    localparam logic [16:0] TRUST_LOW_RST  = 17'd8192;
    localparam logic [16:0] TRUST_HIGH_RST = 17'd32768;
    localparam logic [15:0] BLEND_KEEP_RST = 16'd32113;
    localparam logic [16:0] KEEP_ONE       = 17'd32768;

    // atan(2^-i) in degrees, q24
    localparam logic [ATAN_W-1:0] ATAN_Q24 [TABLE_LEN] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
        30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
        30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
        30'd234684,    30'd117342,    30'd58671,     30'd29335,
        30'd14668,     30'd7334,      30'd3667,      30'd1833,
        30'd917,       30'd458,       30'd229,       30'd115
    };

endpackage

// ----- hw/rtl/tcf_cordic.sv -----
// iterative cordic atan2 in vectoring mode, one micro-rotation per cycle
// result in degrees with FRAC fraction bits; uses tcf_pkg
module tcf_cordic #(
    parameter int STEPS = tcf_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC  = tcf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [tcf_pkg::SAMPLE_W-1:0]  y_in,
    input  logic signed [tcf_pkg::SAMPLE_W-1:0]  x_in,
    output logic                                 done,
    output logic signed [tcf_pkg::ANGLE_W-1:0]   tilt
);

    localparam int STEPS_EFF = (STEPS < tcf_pkg::TABLE_LEN) ? STEPS : tcf_pkg::TABLE_LEN;
    localparam int CNT_W     = $clog2(STEPS_EFF);
    localparam int XY_W      = tcf_pkg::XY_W;
    localparam int Z_W       = tcf_pkg::Z_W;
    localparam int RND_SH    = tcf_pkg::TABLE_FRAC - FRAC;
    localparam logic signed [Z_W-1:0] RND_ADD = Z_W'(1) << (RND_SH - 1);
    localparam logic signed [Z_W-1:0] QUARTER =
        Z_W'({tcf_pkg::ATAN_Q24[0], 1'b0});

    typedef enum logic [1:0] {
        C_IDLE,
        C_ITER,
        C_ROUND
    } cstate_t;

    cstate_t                 state_reg;
    logic [CNT_W-1:0]        iter_reg;
    logic signed [XY_W-1:0]  x_reg;
    logic signed [XY_W-1:0]  y_reg;
    logic signed [Z_W-1:0]   z_reg;
    logic                    zero_reg;
    logic                    done_reg;
    logic signed [tcf_pkg::ANGLE_W-1:0] tilt_reg;

    logic signed [XY_W-1:0]  xs;
    logic signed [XY_W-1:0]  ys;
    logic signed [XY_W-1:0]  dx;
    logic signed [XY_W-1:0]  dy;
    logic signed [Z_W-1:0]   step_angle;
    logic signed [Z_W-1:0]   z_round;
    logic                    y_pos;

    assign xs = {{3{x_in[15]}}, x_in, {tcf_pkg::INPUT_SHIFT{1'b0}}};
    assign ys = {{3{y_in[15]}}, y_in, {tcf_pkg::INPUT_SHIFT{1'b0}}};
    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;
    assign step_angle = Z_W'(tcf_pkg::ATAN_Q24[tcf_pkg::TABLE_IDX_W'(iter_reg)]);
    assign y_pos = !y_reg[XY_W-1] && (y_reg != '0);
    assign z_round = (z_reg + RND_ADD) >>> RND_SH;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            iter_reg  <= '0;
        end else begin
            done_reg <= (state_reg == C_ROUND);
            unique case (state_reg)
                C_IDLE: begin
                    if (start) begin
                        zero_reg  <= (x_in == '0) && (y_in == '0);
                        iter_reg  <= '0;
                        state_reg <= C_ITER;
                        if (x_in[15]) begin
                            if (!y_in[15]) begin
                                x_reg <= ys;
                                y_reg <= -xs;
                                z_reg <= QUARTER;
                            end else begin
                                x_reg <= -ys;
                                y_reg <= xs;
                                z_reg <= -QUARTER;
                            end
                        end else begin
                            x_reg <= xs;
                            y_reg <= ys;
                            z_reg <= '0;
                        end
                    end
                end
                C_ITER: begin
                    if (y_pos) begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + step_angle;
                    end else begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - step_angle;
                    end
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == CNT_W'(STEPS_EFF - 1)) begin
                        state_reg <= C_ROUND;
                    end
                end
                C_ROUND: begin
                    tilt_reg  <= zero_reg ? '0 : z_round[tcf_pkg::ANGLE_W-1:0];
                    state_reg <= C_IDLE;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign tilt = tilt_reg;

endmodule

// ----- hw/rtl/tilt_complementary_filter_unit.sv -----
// sequence: gyro update of pitch and roll, then, if the acceleration is trusted, a cordic
//   run and blend for pitch and then for roll; no new request is taken meanwhile
// throughput: set by the two cordic runs (with correction), the single shared multiplier
//   and m_tready stalls at the output; s_tready returns when the result is loaded
// reset: synchronous active-low aresetn clears angles, registers to defaults, output invalid
// top level: sequencer, shared multiplier, apb registers; uses tcf_pkg and tcf_cordic
module tilt_complementary_filter_unit #(
    parameter int CORDIC_STEPS    = tcf_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // accel_x, accel_y, accel_z, rate_x, rate_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // pitch_out, roll_out
    output logic [0:0]  m_tuser,   // accel_used
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = tcf_pkg::ANGLE_W;
    localparam int PW = 50;
    localparam int SW = 51;

    typedef enum logic [1:0] {
        REG_GYRO_SCALE = 2'd0,
        REG_TRUST_LOW  = 2'd1,
        REG_TRUST_HIGH = 2'd2,
        REG_BLEND_KEEP = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GP,
        S_GR,
        S_GW,
        S_CSTART,
        S_CWAIT,
        S_B1,
        S_B2,
        S_B3,
        S_B4,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [15:0] gyro_scale_reg;
    logic [16:0] trust_low_reg;
    logic [16:0] trust_high_reg;
    logic [15:0] blend_keep_reg;

    logic signed [15:0]   ax_reg, ay_reg, az_reg, rx_reg, ry_reg;
    logic                 used_reg;
    logic                 phase_reg;
    logic signed [AW-1:0] pitch_reg;
    logic signed [AW-1:0] roll_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [SW-1:0] acc_reg;
    logic                 m_tvalid_reg;
    logic [63:0]          m_tdata_reg;
    logic                 m_tuser_reg;

    logic signed [AW-1:0] mul_a;
    logic [17:0]          mul_b;
    logic signed [PW-1:0] prod_next;
    logic [16:0]          keep_eff;
    logic [16:0]          keep_comp;
    logic [16:0]          abs_x, abs_y, abs_z;
    logic [17:0]          mag;
    logic                 used_next;
    logic signed [AW-1:0] angle_sel;
    logic signed [SW-1:0] gyro_sum;
    logic signed [SW-1:0] blend_shift;
    logic                 cordic_start;
    logic signed [15:0]   cordic_y;
    logic                 cordic_done;
    logic signed [AW-1:0] cordic_tilt;
    logic                 cfg_write;

    function automatic logic signed [AW-1:0] sat32(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = SW'({1'b0, {(AW-1){1'b1}}});
        lo = -hi - SW'(1);
        if (v > hi) begin
            return hi[AW-1:0];
        end else if (v < lo) begin
            return lo[AW-1:0];
        end
        return v[AW-1:0];
    endfunction

    // apb registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gyro_scale_reg <= tcf_pkg::GYRO_SCALE_RST;
            trust_low_reg  <= tcf_pkg::TRUST_LOW_RST;
            trust_high_reg <= tcf_pkg::TRUST_HIGH_RST;
            blend_keep_reg <= tcf_pkg::BLEND_KEEP_RST;
        end else if (cfg_write) begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_GYRO_SCALE: gyro_scale_reg <= pwdata[15:0];
                REG_TRUST_LOW:  trust_low_reg  <= pwdata[16:0];
                REG_TRUST_HIGH: trust_high_reg <= pwdata[16:0];
                REG_BLEND_KEEP: blend_keep_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_GYRO_SCALE: prdata = 32'(gyro_scale_reg);
            REG_TRUST_LOW:  prdata = 32'(trust_low_reg);
            REG_TRUST_HIGH: prdata = 32'(trust_high_reg);
            REG_BLEND_KEEP: prdata = 32'(blend_keep_reg);
            default:        prdata = '0;
        endcase
    end

    // acceleration magnitude and trust window
    assign abs_x = s_tdata[15] ? (17'd0 - {1'b1, s_tdata[15:0]}) : {1'b0, s_tdata[15:0]};
    assign abs_y = s_tdata[31] ? (17'd0 - {1'b1, s_tdata[31:16]}) : {1'b0, s_tdata[31:16]};
    assign abs_z = s_tdata[47] ? (17'd0 - {1'b1, s_tdata[47:32]}) : {1'b0, s_tdata[47:32]};
    assign mag   = 18'(abs_x) + 18'(abs_y) + 18'(abs_z);
    assign used_next = (mag > {1'b0, trust_low_reg}) && (mag < {1'b0, trust_high_reg});

    assign keep_eff  = ({1'b0, blend_keep_reg} > tcf_pkg::KEEP_ONE) ?
                       tcf_pkg::KEEP_ONE : {1'b0, blend_keep_reg};
    assign keep_comp = tcf_pkg::KEEP_ONE - keep_eff;
    assign angle_sel = phase_reg ? roll_reg : pitch_reg;

    // shared multiplier operand select
    always_comb begin
        unique case (state_reg)
            S_GP: begin
                mul_a = AW'(rx_reg);
                mul_b = 18'(gyro_scale_reg);
            end
            S_GR: begin
                mul_a = AW'(0) - AW'(ry_reg);
                mul_b = 18'(gyro_scale_reg);
            end
            S_B1: begin
                mul_a = angle_sel;
                mul_b = 18'(keep_eff);
            end
            S_B2: begin
                mul_a = cordic_tilt;
                mul_b = 18'(keep_comp);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next   = PW'(mul_a) * $signed(PW'(mul_b));
    assign gyro_sum    = SW'(angle_sel) + SW'(prod_reg);
    assign blend_shift = acc_reg >>> 15;

    assign cordic_start = (state_reg == S_CSTART);
    assign cordic_y     = phase_reg ? ax_reg : ay_reg;

    tcf_cordic #(
        .STEPS (CORDIC_STEPS),
        .FRAC  (ANGLE_FRAC_BITS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .y_in    (cordic_y),
        .x_in    (az_reg),
        .done    (cordic_done),
        .tilt    (cordic_tilt)
    );

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pitch_reg    <= '0;
            roll_reg     <= '0;
            phase_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        ax_reg    <= s_tdata[15:0];
                        ay_reg    <= s_tdata[31:16];
                        az_reg    <= s_tdata[47:32];
                        rx_reg    <= s_tdata[63:48];
                        ry_reg    <= s_tdata[79:64];
                        used_reg  <= used_next;
                        phase_reg <= 1'b0;
                        state_reg <= S_GP;
                    end
                end
                S_GP: state_reg <= S_GR;
                S_GR: begin
                    pitch_reg <= sat32(gyro_sum);
                    phase_reg <= 1'b1;
                    state_reg <= S_GW;
                end
                S_GW: begin
                    roll_reg  <= sat32(gyro_sum);
                    phase_reg <= 1'b0;
                    state_reg <= used_reg ? S_CSTART : S_DONE;
                end
                S_CSTART: state_reg <= S_CWAIT;
                S_CWAIT: begin
                    if (cordic_done) begin
                        state_reg <= S_B1;
                    end
                end
                S_B1: state_reg <= S_B2;
                S_B2: begin
                    acc_reg   <= SW'(prod_reg);
                    state_reg <= S_B3;
                end
                S_B3: begin
                    acc_reg   <= acc_reg + SW'(prod_reg) + SW'(16384);
                    state_reg <= S_B4;
                end
                S_B4: begin
                    if (phase_reg) begin
                        roll_reg  <= sat32(blend_shift);
                        state_reg <= S_DONE;
                    end else begin
                        pitch_reg <= sat32(blend_shift);
                        phase_reg <= 1'b1;
                        state_reg <= S_CSTART;
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {roll_reg, pitch_reg};
                        m_tuser_reg  <= used_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

// ----- hw/rtl/tcf_checks.sv -----
// port-level checks for tilt_complementary_filter_unit, attached by bind
// no package dependencies
module tcf_checks (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // reset empties the output
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // an accepted request keeps the block busy, with input ready held low after it
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input ready too soon after a request");

    // a new result comes with the input side free again
    a_ready_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result loaded while still busy");

endmodule

bind tilt_complementary_filter_unit tcf_checks u_tcf_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
